>>> design/brp_pkg.sv
// Shared types, codes and tables of the bytecode opcode remap parser.
`timescale 1ns / 1ps
`default_nettype none
package brp_pkg;

   // Nesting limit and child count stack geometry
   localparam int MAX_NEST    = 64;
   localparam int STACK_DEPTH = MAX_NEST + 1;
   localparam int NEST_W      = $clog2(STACK_DEPTH);

   localparam int LEN_W = 22;
   localparam int HDR_LEN = 23;
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(24);

   // Status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_SHORT     = 4'd1;
   localparam logic [3:0] ST_SIG       = 4'd2;
   localparam logic [3:0] ST_NOT32     = 4'd3;
   localparam logic [3:0] ST_MARKERS   = 4'd4;
   localparam logic [3:0] ST_TRUNC     = 4'd5;
   localparam logic [3:0] ST_OVERSIZE  = 4'd6;
   localparam logic [3:0] ST_INVALID   = 4'd7;
   localparam logic [3:0] ST_BADCONST  = 4'd8;
   localparam logic [3:0] ST_BETA      = 4'd9;
   localparam logic [3:0] ST_DEEP      = 4'd10;
   localparam logic [3:0] ST_TRAILING  = 4'd11;

   // Constant tags
   localparam logic [7:0] TAG_NIL   = 8'd0;
   localparam logic [7:0] TAG_FALSE = 8'd1;
   localparam logic [7:0] TAG_TRUE  = 8'd17;
   localparam logic [7:0] TAG_FLT   = 8'd3;
   localparam logic [7:0] TAG_INT   = 8'd19;
   localparam logic [7:0] TAG_SSTR  = 8'd4;
   localparam logic [7:0] TAG_LSTR  = 8'd20;

   localparam logic [31:0] VINT_LIMIT = 32'h01FF_FFFF;
   localparam logic [3:0]  VINT_MAX_BYTES = 4'd10;

   // Section phases of the prototype walk
   typedef enum logic [5:0] {
      PH_HDR, PH_SRC_N, PH_SRC_SK, PH_LINE, PH_LAST, PH_FIX, PH_CODE_N, PH_CODE,
      PH_K_N, PH_K_HEAD, PH_K_TAG, PH_K_NUM, PH_K_SLEN, PH_K_SSK, PH_UP_N,
      PH_UP_SK, PH_P_N, PH_CH_HEAD, PH_LI_N, PH_LI_SK, PH_AB_N, PH_AB_HEAD,
      PH_AB_A, PH_AB_B, PH_LV_N, PH_LV_HEAD, PH_LV_SLEN, PH_LV_SSK, PH_LV_A,
      PH_LV_B, PH_UV_N, PH_UV_HEAD, PH_UV_SLEN, PH_UV_SSK, PH_END, PH_DONE,
      PH_ERR
   } phase_type;

   // One classified beat, front to back
   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic [LEN_W-1:0] rem;
      logic             short_len;
      logic             hdr_end;
      logic [4:0]       hdr_idx;
   } beat_type;

   // Expected header signature and format bytes
   function automatic logic [7:0] hdr_byte(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0:  r = 8'h1b;
         5'd1:  r = 8'h4c;
         5'd2:  r = 8'h75;
         5'd3:  r = 8'h61;
         5'd4:  r = 8'h54;
         5'd5:  r = 8'h00;
         5'd6:  r = 8'h19;
         5'd7:  r = 8'h93;
         5'd8:  r = 8'h0d;
         5'd9:  r = 8'h0a;
         5'd10: r = 8'h1a;
         5'd11: r = 8'h0a;
         5'd12: r = 8'h04;
         5'd13: r = 8'h04;
         5'd14: r = 8'h04;
         5'd15: r = 8'h78;
         5'd16: r = 8'h56;
         5'd17: r = 8'h00;
         5'd18: r = 8'h00;
         5'd19: r = 8'h00;
         5'd20: r = 8'h40;
         5'd21: r = 8'hb9;
         5'd22: r = 8'h43;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/brp_front.sv
// Front end: byte position counter and per-beat classification.
`timescale 1ns / 1ps
`default_nettype none
module brp_front import brp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       in_byte,
   input  wire logic [LEN_W-1:0] chunk_length,
   output beat_type              beat
);
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W:0]   pos_inc;
   logic             last;

   // Last byte when position+1 reaches the length
   always_comb begin
      pos_inc = {1'b0, pos_ff} + (LEN_W+1)'(1);
      last = pos_inc >= {1'b0, chunk_length};
      beat.data = in_byte;
      beat.last = last;
      beat.rem = last ? '0 : LEN_W'({1'b0, chunk_length} - pos_inc);
      beat.short_len = chunk_length < MIN_LEN;
      beat.hdr_end = pos_ff >= LEN_W'(HDR_LEN);
      beat.hdr_idx = pos_ff[4:0];
      pos_in = last ? '0 : pos_inc[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
      end
   end
endmodule
`default_nettype wire

>>> design/brp_queue.sv
// Two-entry queue of classified beats between front and back.
`timescale 1ns / 1ps
`default_nettype none
module brp_queue import brp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  beat_type  wr_beat,
   output logic      full,
   input  wire logic pop,
   output beat_type  rd_beat,
   output logic      empty
);
   beat_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rd_beat = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_beat;
   end
endmodule
`default_nettype wire

>>> design/brp_back.sv
// Back end: prototype walker, opcode remap, child count stack, result register.
`timescale 1ns / 1ps
`default_nettype none
module brp_back import brp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  beat_type  beat,
   input  wire logic beat_empty,
   output logic      beat_pop,
   input  wire logic rsp_pop,
   output logic      rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic      rsp_final_res,
   output logic [3:0] rsp_status
);
   phase_type         phase_ff, phase_in;
   logic [31:0]       vval_ff, vval_in;
   logic [3:0]        vbytes_ff, vbytes_in;
   logic [31:0]       items_ff, items_in;
   logic [31:0]       skip_ff, skip_in;
   logic [NEST_W-1:0] depth_ff, depth_in;
   logic [31:0]       top_ff, top_in;
   logic [3:0]        err_ff, err_in;
   logic [31:0]       parent_ff;
   logic [31:0]       stack_mem [STACK_DEPTH];
   logic              push_we;
   logic [31:0]       push_data;
   logic [NEST_W-1:0] push_addr;
   logic [NEST_W-1:0] rd_addr;

   logic              vld_ff;
   logic [7:0]        ob_ff;
   logic              fin_ff;
   logic [3:0]        st_ff;
   logic [7:0]        ob;
   logic [3:0]        st;

   logic              advance;
   logic              is_vint, go, stop;
   logic [31:0]       v, nv;
   logic [3:0]        nb;
   logic [6:0]        op;
   logic [33:0]       v_ext;
   logic [33:0]       rem_ext;

   assign advance = !beat_empty && (!vld_ff || rsp_pop);
   assign beat_pop = advance;

   // Step one beat through the walk, then settle zero-length items
   always_comb begin
      phase_in = phase_ff;
      vval_in = vval_ff;
      vbytes_in = vbytes_ff;
      items_in = items_ff;
      skip_in = skip_ff;
      depth_in = depth_ff;
      top_in = top_ff;
      err_in = err_ff;
      push_we = 1'b0;
      push_data = '0;
      push_addr = '0;
      ob = beat.data;
      st = ST_OK;
      v = '0;
      nv = {vval_ff[24:0], beat.data[6:0]};
      nb = vbytes_ff + 4'd1;
      op = beat.data[6:0];
      go = 1'b1;
      stop = 1'b0;
      rem_ext = {12'd0, beat.rem};
      is_vint = !(phase_ff inside {PH_HDR, PH_ERR, PH_DONE, PH_SRC_SK, PH_FIX,
                                   PH_CODE, PH_K_NUM, PH_K_SSK, PH_UP_SK,
                                   PH_LI_SK, PH_LV_SSK, PH_UV_SSK, PH_K_TAG});

      // Varint accumulation
      if (is_vint) begin
         if (vval_ff > VINT_LIMIT) begin
            err_in = ST_OVERSIZE;
            phase_in = PH_ERR;
            go = 1'b0;
         end else if (beat.data[7]) begin
            v = nv;
            vval_in = '0;
            vbytes_in = '0;
         end else begin
            vval_in = nv;
            vbytes_in = nb;
            go = 1'b0;
            if (nb >= VINT_MAX_BYTES) begin
               err_in = ST_INVALID;
               phase_in = PH_ERR;
            end
         end
      end
      v_ext = {2'b00, v};

      if (go) begin
         case (phase_ff)
            PH_HDR: begin
               if (beat.short_len) begin
                  err_in = ST_SHORT;
                  phase_in = PH_ERR;
               end else if (!beat.hdr_end) begin
                  if (beat.data != hdr_byte(beat.hdr_idx)) begin
                     phase_in = PH_ERR;
                     if (beat.hdr_idx < 5'd6) err_in = ST_SIG;
                     else if (beat.hdr_idx < 5'd15) err_in = ST_NOT32;
                     else err_in = ST_MARKERS;
                  end
               end else begin
                  depth_in = '0;
                  phase_in = PH_SRC_N;
               end
            end
            PH_SRC_SK, PH_FIX, PH_K_NUM, PH_K_SSK, PH_UP_SK, PH_LI_SK, PH_LV_SSK,
            PH_UV_SSK: begin
               if (skip_ff != '0) skip_in = skip_ff - 32'd1;
            end
            PH_CODE: begin
               if (skip_ff[1:0] == 2'd0) begin
                  if (op <= 7'd4) begin
                     ob = beat.data;
                  end else if (op >= 7'd6 && op <= 7'd80) begin
                     ob = {beat.data[7], op + 7'd2};
                  end else if (op >= 7'd81 && op <= 7'd83) begin
                     ob = {beat.data[7], op - 7'd76};
                  end else begin
                     err_in = ST_BETA;
                     phase_in = PH_ERR;
                  end
               end
               if (phase_in != PH_ERR && skip_ff != '0) skip_in = skip_ff - 32'd1;
            end
            PH_K_TAG: begin
               case (beat.data)
                  TAG_NIL, TAG_FALSE, TAG_TRUE: phase_in = PH_K_HEAD;
                  TAG_FLT, TAG_INT: begin
                     skip_in = 32'd4;
                     phase_in = PH_K_NUM;
                  end
                  TAG_SSTR, TAG_LSTR: phase_in = PH_K_SLEN;
                  default: begin
                     err_in = ST_BADCONST;
                     phase_in = PH_ERR;
                  end
               endcase
            end
            PH_SRC_N: begin
               skip_in = (v == '0) ? '0 : v - 32'd1;
               phase_in = PH_SRC_SK;
            end
            PH_LINE: phase_in = PH_LAST;
            PH_LAST: begin
               skip_in = 32'd3;
               phase_in = PH_FIX;
            end
            PH_CODE_N: begin
               if ({v_ext[31:0], 2'b00} > rem_ext) begin
                  err_in = ST_TRUNC;
                  phase_in = PH_ERR;
               end else begin
                  skip_in = {v[29:0], 2'b00};
                  phase_in = PH_CODE;
               end
            end
            PH_K_N: begin
               items_in = v;
               phase_in = PH_K_HEAD;
            end
            PH_K_SLEN: begin
               skip_in = (v == '0) ? '0 : v - 32'd1;
               phase_in = PH_K_SSK;
            end
            PH_UP_N: begin
               if (v_ext + {v_ext[32:0], 1'b0} > rem_ext) begin
                  err_in = ST_TRUNC;
                  phase_in = PH_ERR;
               end else begin
                  skip_in = v + {v[30:0], 1'b0};
                  phase_in = PH_UP_SK;
               end
            end
            PH_P_N: begin
               top_in = v;
               phase_in = PH_CH_HEAD;
            end
            PH_LI_N: begin
               if (v_ext > rem_ext) begin
                  err_in = ST_TRUNC;
                  phase_in = PH_ERR;
               end else begin
                  skip_in = v;
                  phase_in = PH_LI_SK;
               end
            end
            PH_AB_N: begin
               items_in = v;
               phase_in = PH_AB_HEAD;
            end
            PH_AB_A: phase_in = PH_AB_B;
            PH_AB_B: phase_in = PH_AB_HEAD;
            PH_LV_N: begin
               items_in = v;
               phase_in = PH_LV_HEAD;
            end
            PH_LV_SLEN: begin
               skip_in = (v == '0) ? '0 : v - 32'd1;
               phase_in = PH_LV_SSK;
            end
            PH_LV_A: phase_in = PH_LV_B;
            PH_LV_B: phase_in = PH_LV_HEAD;
            PH_UV_N: begin
               items_in = v;
               phase_in = PH_UV_HEAD;
            end
            PH_UV_SLEN: begin
               skip_in = (v == '0) ? '0 : v - 32'd1;
               phase_in = PH_UV_SSK;
            end
            PH_DONE: begin
               err_in = ST_TRAILING;
               phase_in = PH_ERR;
            end
            default: ;
         endcase

         // Settle: at most a handful of non-consuming transitions
         for (int i = 0; i < 6; i++) begin
            if (!stop) begin
               case (phase_in)
                  PH_SRC_SK, PH_FIX, PH_CODE, PH_K_NUM, PH_K_SSK, PH_UP_SK,
                  PH_LI_SK, PH_LV_SSK, PH_UV_SSK: begin
                     if (skip_in != '0) begin
                        stop = 1'b1;
                     end else begin
                        case (phase_in)
                           PH_SRC_SK: phase_in = PH_LINE;
                           PH_FIX:    phase_in = PH_CODE_N;
                           PH_CODE:   phase_in = PH_K_N;
                           PH_UP_SK:  phase_in = PH_P_N;
                           PH_LI_SK:  phase_in = PH_AB_N;
                           PH_LV_SSK: phase_in = PH_LV_A;
                           PH_UV_SSK: phase_in = PH_UV_HEAD;
                           default:   phase_in = PH_K_HEAD;
                        endcase
                     end
                  end
                  PH_K_HEAD, PH_AB_HEAD, PH_LV_HEAD, PH_UV_HEAD: begin
                     if (items_in == '0) begin
                        case (phase_in)
                           PH_K_HEAD:  phase_in = PH_UP_N;
                           PH_AB_HEAD: phase_in = PH_LV_N;
                           PH_LV_HEAD: phase_in = PH_UV_N;
                           default:    phase_in = PH_END;
                        endcase
                     end else begin
                        items_in = items_in - 32'd1;
                        case (phase_in)
                           PH_K_HEAD:  phase_in = PH_K_TAG;
                           PH_AB_HEAD: phase_in = PH_AB_A;
                           PH_LV_HEAD: phase_in = PH_LV_SLEN;
                           default:    phase_in = PH_UV_SLEN;
                        endcase
                     end
                  end
                  PH_CH_HEAD: begin
                     if (top_in == '0) begin
                        phase_in = PH_LI_N;
                     end else if (depth_in == NEST_W'(MAX_NEST)) begin
                        err_in = ST_DEEP;
                        phase_in = PH_ERR;
                        stop = 1'b1;
                     end else begin
                        // Push: park the decremented count, child gets a new top
                        push_we = 1'b1;
                        push_data = top_in - 32'd1;
                        push_addr = depth_in;
                        depth_in = depth_in + NEST_W'(1);
                        phase_in = PH_SRC_N;
                     end
                  end
                  PH_END: begin
                     if (depth_in == '0) begin
                        phase_in = PH_DONE;
                     end else begin
                        depth_in = depth_in - NEST_W'(1);
                        top_in = parent_ff;
                        phase_in = PH_CH_HEAD;
                     end
                  end
                  default: stop = 1'b1;
               endcase
            end
         end
      end

      if (beat.last) begin
         if (err_in != ST_OK) st = err_in;
         else st = (phase_in == PH_DONE) ? ST_OK : ST_TRUNC;
      end
   end

   // Walk state; the last beat returns everything to reset
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         vval_ff <= '0;
         vbytes_ff <= '0;
         items_ff <= '0;
         skip_ff <= '0;
         depth_ff <= '0;
         top_ff <= '0;
         err_ff <= ST_OK;
      end else if (advance) begin
         if (beat.last) begin
            phase_ff <= PH_HDR;
            vval_ff <= '0;
            vbytes_ff <= '0;
            items_ff <= '0;
            skip_ff <= '0;
            depth_ff <= '0;
            top_ff <= '0;
            err_ff <= ST_OK;
         end else begin
            phase_ff <= phase_in;
            vval_ff <= vval_in;
            vbytes_ff <= vbytes_in;
            items_ff <= items_in;
            skip_ff <= skip_in;
            depth_ff <= depth_in;
            top_ff <= top_in;
            err_ff <= err_in;
         end
      end
   end

   // Child count stack: parent of the current level is read every cycle
   assign rd_addr = (depth_ff == '0) ? '0 : depth_ff - NEST_W'(1);

   always_ff @(posedge clock) begin
      if (advance && push_we) stack_mem[push_addr] <= push_data;
      parent_ff <= stack_mem[rd_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= 1'b1;
      end else if (rsp_pop) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ob_ff <= ob;
         fin_ff <= beat.last;
         st_ff <= st;
      end
   end

   assign rsp_empty = !vld_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_final_res = fin_ff;
   assign rsp_status = st_ff;
endmodule
`default_nettype wire

>>> design/bytecode_opcode_remap_parser_core.sv
// Top level of the bytecode opcode remap parser.
//
//  channel  handshake      beat contents
//  req      push / full    req_in_byte, req_chunk_length
//  rsp      pop / empty    rsp_out_byte, rsp_final_res, rsp_status
//
// One byte per cycle sustained while the result side keeps popping; an accepted
// byte passes through the queue, then the result register, to the result ports.
// Each byte is parsed by the back end's phase and stack logic.
// Reset is synchronous and returns the byte position and walk to the header.
// A stalled result side fills the two-entry queue, then raises full.
`timescale 1ns / 1ps
`default_nettype none
module bytecode_opcode_remap_parser_core import brp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic [LEN_W-1:0] req_chunk_length,
   output logic                  empty,
   input  wire logic             pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_final_res,
   output logic [3:0]            rsp_status
);
   beat_type wr_beat, rd_beat;
   logic     q_empty, q_pop, take;

   assign take = push && !full;

   brp_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .in_byte(req_in_byte), .chunk_length(req_chunk_length), .beat(wr_beat)
   );

   brp_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .wr_beat(wr_beat), .full(full),
      .pop(q_pop), .rd_beat(rd_beat), .empty(q_empty)
   );

   brp_back u_back (
      .clock(clock), .reset(reset), .beat(rd_beat), .beat_empty(q_empty),
      .beat_pop(q_pop), .rsp_pop(pop), .rsp_empty(empty),
      .rsp_out_byte(rsp_out_byte), .rsp_final_res(rsp_final_res),
      .rsp_status(rsp_status)
   );
endmodule
`default_nettype wire

>>> sim/tb_bytecode_opcode_remap_parser_core.sv
// Testbench for the bytecode opcode remap parser: chunk generator, predictor and checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_bytecode_opcode_remap_parser_core;
   import brp_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int TOTAL_BYTES = 1500;
   localparam int MIN_RANDOM_BYTES = 200;

   // Chunk recipes for the stimulus generator
   typedef enum int {
      K_GOOD, K_DEEPEST, K_SHORT, K_SIG, K_NOT32, K_MARK, K_TRUNC, K_OVERSIZE,
      K_INVALID, K_BADK, K_BETA, K_DEEP, K_TRAIL, K_FLIP, K_NOISE
   } recipe_kind_type;

   typedef struct {
      recipe_kind_type kind;
      logic            tchk;
      logic [3:0]      tst;
   } recipe_row_type;

   typedef struct {
      logic [7:0]       b;
      logic [LEN_W-1:0] len;
      logic             tchk;
      logic [3:0]       tst;
   } req_beat_type;

   typedef struct {
      logic [7:0] ob;
      logic       fin;
      logic [3:0] st;
      logic       tchk;
      logic [3:0] tst;
   } rsp_expect_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic [7:0]       req_in_byte = 8'h00;
   logic [LEN_W-1:0] req_chunk_length = '0;
   logic             pop = 1'b0;
   logic             full, empty;
   logic [7:0]       rsp_out_byte;
   logic             rsp_final_res;
   logic [3:0]       rsp_status;

   bytecode_opcode_remap_parser_core i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_in_byte(req_in_byte), .req_chunk_length(req_chunk_length),
      .empty(empty), .pop(pop), .rsp_out_byte(rsp_out_byte),
      .rsp_final_res(rsp_final_res), .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor state
   // ---------------------------------------------------------------
   logic [7:0]       magic [0:22];
   logic [LEN_W-1:0] p_pos;
   phase_type        p_ph;
   logic [31:0]      p_vval;
   logic [3:0]       p_vcnt;
   logic [31:0]      p_items;
   logic [31:0]      p_skip;
   logic [31:0]      p_kids [0:STACK_DEPTH-1];
   int unsigned      p_depth;
   logic [3:0]       p_err;

   function automatic void walk_clear();
      p_pos = '0; p_ph = PH_HDR; p_vval = '0; p_vcnt = '0; p_items = '0;
      p_skip = '0; p_depth = 0; p_err = ST_OK;
      for (int i = 0; i < STACK_DEPTH; i++) p_kids[i] = '0;
   endfunction

   function automatic void walk_fail(input logic [3:0] code);
      if (p_err == ST_OK) p_err = code;
      p_ph = PH_ERR;
   endfunction

   // Skip phases and the phase each one falls through to when drained
   function automatic logic is_skip(input phase_type ph);
      return ph inside {PH_SRC_SK, PH_FIX, PH_CODE, PH_K_NUM, PH_K_SSK, PH_UP_SK,
                        PH_LI_SK, PH_LV_SSK, PH_UV_SSK};
   endfunction

   function automatic phase_type skip_target(input phase_type ph);
      case (ph)
         PH_SRC_SK: return PH_LINE;
         PH_FIX:    return PH_CODE_N;
         PH_CODE:   return PH_K_N;
         PH_K_NUM:  return PH_K_HEAD;
         PH_K_SSK:  return PH_K_HEAD;
         PH_UP_SK:  return PH_P_N;
         PH_LI_SK:  return PH_AB_N;
         PH_LV_SSK: return PH_LV_A;
         default:   return PH_UV_HEAD;
      endcase
   endfunction

   // Fall through empty items and loop heads until a byte is needed
   function automatic void walk_settle();
      while (1'b1) begin
         if (is_skip(p_ph)) begin
            if (p_skip != 0) return;
            p_ph = skip_target(p_ph);
         end else begin
            case (p_ph)
               PH_K_HEAD: if (p_items == 0) p_ph = PH_UP_N;
                          else begin p_items--; p_ph = PH_K_TAG; end
               PH_AB_HEAD: if (p_items == 0) p_ph = PH_LV_N;
                          else begin p_items--; p_ph = PH_AB_A; end
               PH_LV_HEAD: if (p_items == 0) p_ph = PH_UV_N;
                          else begin p_items--; p_ph = PH_LV_SLEN; end
               PH_UV_HEAD: if (p_items == 0) p_ph = PH_END;
                          else begin p_items--; p_ph = PH_UV_SLEN; end
               PH_CH_HEAD: begin
                  if (p_depth > MAX_NEST) begin walk_fail(ST_TRUNC); return; end
                  if (p_kids[p_depth] == 0) p_ph = PH_LI_N;
                  else if (p_depth + 1 > MAX_NEST) begin walk_fail(ST_DEEP); return; end
                  else begin
                     p_kids[p_depth]--;
                     p_depth++;
                     p_ph = PH_SRC_N;
                  end
               end
               PH_END: if (p_depth == 0) p_ph = PH_DONE;
                       else begin p_depth--; p_ph = PH_CH_HEAD; end
               default: return;
            endcase
         end
      end
   endfunction

   // One varint byte: 1 complete, 0 pending, -1 error
   function automatic int varint_feed(input logic [7:0] b);
      if (p_vval > VINT_LIMIT) begin walk_fail(ST_OVERSIZE); return -1; end
      p_vval = {p_vval[24:0], b[6:0]};
      p_vcnt++;
      if (b[7]) begin p_vcnt = '0; return 1; end
      if (p_vcnt >= VINT_MAX_BYTES) begin walk_fail(ST_INVALID); return -1; end
      return 0;
   endfunction

   function automatic logic [31:0] str_body(input logic [31:0] n);
      return (n == 0) ? 32'd0 : n - 1;
   endfunction

   // Expected result for one byte of the chunk
   function automatic rsp_expect_type remap_predict(input req_beat_type rq);
      rsp_expect_type e;
      logic [31:0]    len, v, rem;
      logic           last, live;
      phase_type      cur;
      int             r;
      logic [6:0]     op, nop;
      len = 32'(rq.len);
      e.ob = rq.b; e.st = ST_OK; e.tchk = rq.tchk; e.tst = rq.tst;
      last = (32'(p_pos) + 1) >= len;
      rem = last ? 32'd0 : len - 32'(p_pos) - 1;
      cur = p_ph;
      v = '0;
      live = 1'b1;
      if (cur != PH_HDR && cur != PH_ERR && cur != PH_DONE && !is_skip(cur) &&
          cur != PH_K_TAG) begin
         r = varint_feed(rq.b);
         if (r <= 0) live = 1'b0;
         else begin v = p_vval; p_vval = '0; end
      end
      if (live) begin
         case (cur)
            PH_HDR: begin
               if (len < 32'(MIN_LEN)) walk_fail(ST_SHORT);
               else if (p_pos < HDR_LEN) begin
                  if (rq.b != magic[p_pos])
                     walk_fail(p_pos < 6 ? ST_SIG : (p_pos < 15 ? ST_NOT32 : ST_MARKERS));
               end else begin
                  p_depth = 0;
                  p_ph = PH_SRC_N;
               end
            end
            PH_SRC_SK, PH_FIX, PH_K_NUM, PH_K_SSK, PH_UP_SK, PH_LI_SK, PH_LV_SSK,
            PH_UV_SSK: if (p_skip != 0) p_skip--;
            PH_CODE: begin
               if (p_skip[1:0] == 2'd0) begin
                  op = rq.b[6:0];
                  if (op <= 4) nop = op;
                  else if (op >= 6 && op <= 80) nop = op + 2;
                  else if (op >= 81 && op <= 83) nop = op - 76;
                  else begin walk_fail(ST_BETA); nop = op; end
                  if (p_ph != PH_ERR) e.ob = {rq.b[7], nop};
               end
               if (p_ph != PH_ERR && p_skip != 0) p_skip--;
            end
            PH_K_TAG: begin
               if (rq.b inside {TAG_NIL, TAG_FALSE, TAG_TRUE}) p_ph = PH_K_HEAD;
               else if (rq.b inside {TAG_FLT, TAG_INT}) begin
                  p_skip = 32'd4; p_ph = PH_K_NUM;
               end else if (rq.b inside {TAG_SSTR, TAG_LSTR}) p_ph = PH_K_SLEN;
               else walk_fail(ST_BADCONST);
            end
            PH_SRC_N: begin p_skip = str_body(v); p_ph = PH_SRC_SK; end
            PH_LINE: p_ph = PH_LAST;
            PH_LAST: begin p_skip = 32'd3; p_ph = PH_FIX; end
            PH_CODE_N: if (v > rem / 4) walk_fail(ST_TRUNC);
                       else begin p_skip = v * 4; p_ph = PH_CODE; end
            PH_K_N: begin p_items = v; p_ph = PH_K_HEAD; end
            PH_K_SLEN: begin p_skip = str_body(v); p_ph = PH_K_SSK; end
            PH_UP_N: if (v > rem / 3) walk_fail(ST_TRUNC);
                     else begin p_skip = v * 3; p_ph = PH_UP_SK; end
            PH_P_N: begin
               if (p_depth <= MAX_NEST) p_kids[p_depth] = v;
               p_ph = PH_CH_HEAD;
            end
            PH_LI_N: if (v > rem) walk_fail(ST_TRUNC);
                     else begin p_skip = v; p_ph = PH_LI_SK; end
            PH_AB_N: begin p_items = v; p_ph = PH_AB_HEAD; end
            PH_AB_A: p_ph = PH_AB_B;
            PH_AB_B: p_ph = PH_AB_HEAD;
            PH_LV_N: begin p_items = v; p_ph = PH_LV_HEAD; end
            PH_LV_SLEN: begin p_skip = str_body(v); p_ph = PH_LV_SSK; end
            PH_LV_A: p_ph = PH_LV_B;
            PH_LV_B: p_ph = PH_LV_HEAD;
            PH_UV_N: begin p_items = v; p_ph = PH_UV_HEAD; end
            PH_UV_SLEN: begin p_skip = str_body(v); p_ph = PH_UV_SSK; end
            PH_DONE: walk_fail(ST_TRAILING);
            default: ;
         endcase
         walk_settle();
      end
      e.fin = last;
      if (last) begin
         if (p_err != ST_OK) e.st = p_err;
         else e.st = (p_ph == PH_DONE) ? ST_OK : ST_TRUNC;
         walk_clear();
      end else begin
         p_pos = p_pos + 1;
      end
      return e;
   endfunction

   // ---------------------------------------------------------------
   // Chunk generator
   // ---------------------------------------------------------------
   logic [7:0]   chunk_bytes [$];
   req_beat_type stim [$];
   logic         want_beta, want_badk;
   int           bad_int;

   function automatic logic [31:0] rand_val();
      if ($urandom_range(0, 3) == 0) return $urandom >> $urandom_range(4, 31);
      return $urandom_range(0, 200);
   endfunction

   // MSB-first 7-bit groups, end mark on the last group
   function automatic void put_varint(input logic [31:0] v);
      int n;
      logic [7:0] g;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0) n++;
      if (n < 4 && $urandom_range(0, 7) == 0) chunk_bytes.push_back(8'h00);
      for (int i = n - 1; i >= 0; i--) begin
         g = {1'b0, 7'(v >> (7 * i))};
         if (i == 0) g[7] = 1'b1;
         chunk_bytes.push_back(g);
      end
   endfunction

   function automatic void put_string();
      int n;
      n = $urandom_range(0, 5);
      put_varint(n);
      for (int i = 1; i < n; i++) chunk_bytes.push_back(8'($urandom));
   endfunction

   // Levels on a nesting chain carry empty sections to keep deep chunks short
   function automatic void put_proto(input int lvl, input int chain);
      int n, kids, pick;
      logic [6:0] op;
      logic [7:0] tag;
      logic lean;
      lean = chain > 0;
      if (lean) put_varint(0);
      else put_string();
      // line defined; broken varints go here in the root
      if (lvl == 0 && bad_int == 1) repeat (5) chunk_bytes.push_back(8'h7f);
      else if (lvl == 0 && bad_int == 2) repeat (10) chunk_bytes.push_back(8'h00);
      else put_varint(lean ? 32'd0 : rand_val());
      put_varint(lean ? 32'd0 : rand_val());
      repeat (3) chunk_bytes.push_back(8'($urandom));
      // instructions
      n = lean ? 0 : $urandom_range(0, 5);
      if (lvl == 0 && want_beta && n == 0) n = 1;
      pick = $urandom_range(0, n - 1);
      put_varint(n);
      for (int i = 0; i < n; i++) begin
         if (lvl == 0 && want_beta && i == pick)
            op = ($urandom_range(0, 3) == 0) ? 7'd5 : 7'($urandom_range(84, 127));
         else begin
            op = 7'($urandom_range(0, 82));
            if (op >= 5) op = op + 1;
         end
         chunk_bytes.push_back({1'($urandom), op});
         repeat (3) chunk_bytes.push_back(8'($urandom));
      end
      // constants
      n = lean ? 0 : $urandom_range(0, 4);
      if (lvl == 0 && want_badk && n == 0) n = 1;
      pick = $urandom_range(0, n - 1);
      put_varint(n);
      for (int i = 0; i < n; i++) begin
         if (lvl == 0 && want_badk && i == pick) begin
            tag = 8'($urandom);
            while (tag inside {TAG_NIL, TAG_FALSE, TAG_TRUE, TAG_FLT, TAG_INT,
                               TAG_SSTR, TAG_LSTR}) tag = 8'($urandom);
            chunk_bytes.push_back(tag);
         end else begin
            case ($urandom_range(0, 6))
               0: tag = TAG_NIL;
               1: tag = TAG_FALSE;
               2: tag = TAG_TRUE;
               3: tag = TAG_FLT;
               4: tag = TAG_INT;
               5: tag = TAG_SSTR;
               default: tag = TAG_LSTR;
            endcase
            chunk_bytes.push_back(tag);
            if (tag == TAG_FLT || tag == TAG_INT)
               repeat (4) chunk_bytes.push_back(8'($urandom));
            else if (tag == TAG_SSTR || tag == TAG_LSTR) put_string();
         end
      end
      // upvalue descriptors
      n = lean ? 0 : $urandom_range(0, 3);
      put_varint(n);
      repeat (3 * n) chunk_bytes.push_back(8'($urandom));
      // child prototypes
      kids = (chain > 0) ? 1 : ((lvl < 2) ? $urandom_range(0, 2) : 0);
      put_varint(kids);
      for (int i = 0; i < kids; i++) put_proto(lvl + 1, (chain > 0) ? chain - 1 : 0);
      // debug sections
      n = lean ? 0 : $urandom_range(0, 5);
      put_varint(n);
      repeat (n) chunk_bytes.push_back(8'($urandom));
      n = lean ? 0 : $urandom_range(0, 2);
      put_varint(n);
      repeat (2 * n) put_varint(rand_val());
      n = lean ? 0 : $urandom_range(0, 2);
      put_varint(n);
      repeat (n) begin put_string(); put_varint(rand_val()); put_varint(rand_val()); end
      n = lean ? 0 : $urandom_range(0, 2);
      put_varint(n);
      repeat (n) put_string();
   endfunction

   function automatic void queue_chunk(input recipe_row_type row);
      req_beat_type bt;
      int n, cut;
      chunk_bytes.delete();
      want_beta = (row.kind == K_BETA);
      want_badk = (row.kind == K_BADK);
      bad_int = (row.kind == K_OVERSIZE) ? 1 : ((row.kind == K_INVALID) ? 2 : 0);
      if (row.kind == K_SHORT) begin
         n = $urandom_range(1, 23);
         repeat (n) chunk_bytes.push_back(8'($urandom));
      end else if (row.kind == K_NOISE) begin
         // random bytes with random lengths on every beat, closed by a zero length
         n = $urandom_range(1, 40);
         for (int i = 0; i < n; i++) begin
            bt.b = 8'($urandom);
            bt.len = (i == n - 1) ? '0 : LEN_W'($urandom);
            bt.tchk = 1'b0; bt.tst = ST_OK;
            stim.push_back(bt);
         end
         return;
      end else begin
         for (int i = 0; i < HDR_LEN; i++) chunk_bytes.push_back(magic[i]);
         chunk_bytes.push_back(8'($urandom));
         put_proto(0, (row.kind == K_DEEP) ? MAX_NEST + 1 :
                      ((row.kind == K_DEEPEST) ? MAX_NEST : 0));
         case (row.kind)
            K_SIG:   chunk_bytes[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
            K_NOT32: chunk_bytes[$urandom_range(6, 14)] ^= 8'($urandom_range(1, 255));
            K_MARK:  chunk_bytes[$urandom_range(15, 22)] ^= 8'($urandom_range(1, 255));
            K_TRUNC: begin
               cut = $urandom_range(1, chunk_bytes.size() - 24);
               repeat (cut) void'(chunk_bytes.pop_back());
            end
            K_TRAIL: repeat ($urandom_range(1, 3)) chunk_bytes.push_back(8'($urandom));
            K_FLIP:
               chunk_bytes[$urandom_range(0, chunk_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
            default: ;
         endcase
      end
      for (int i = 0; i < chunk_bytes.size(); i++) begin
         bt.b = chunk_bytes[i];
         bt.len = LEN_W'(chunk_bytes.size());
         if (row.kind == K_SHORT && chunk_bytes.size() == 1 && $urandom_range(0, 1))
            bt.len = '0;
         bt.tchk = row.tchk && (i == chunk_bytes.size() - 1);
         bt.tst = row.tst;
         stim.push_back(bt);
      end
   endfunction

   // Directed chunks; status typed in where the recipe fixes it
   recipe_row_type directed [] = '{
      '{K_GOOD,     1'b1, ST_OK},
      '{K_GOOD,     1'b1, ST_OK},
      '{K_DEEPEST,  1'b1, ST_OK},
      '{K_SHORT,    1'b1, ST_SHORT},
      '{K_SIG,      1'b1, ST_SIG},
      '{K_NOT32,    1'b1, ST_NOT32},
      '{K_MARK,     1'b1, ST_MARKERS},
      '{K_TRUNC,    1'b1, ST_TRUNC},
      '{K_OVERSIZE, 1'b1, ST_OVERSIZE},
      '{K_INVALID,  1'b1, ST_INVALID},
      '{K_BADK,     1'b1, ST_BADCONST},
      '{K_BETA,     1'b1, ST_BETA},
      '{K_DEEP,     1'b1, ST_DEEP},
      '{K_TRAIL,    1'b1, ST_TRAILING},
      '{K_NOISE,    1'b0, ST_OK},
      '{K_FLIP,     1'b0, ST_OK}
   };

   // Random chunks fill up to the byte budget, with a short random tail at least
   function automatic void build_stimulus();
      recipe_row_type row;
      int r;
      foreach (directed[i]) queue_chunk(directed[i]);
      r = stim.size();
      while (stim.size() < TOTAL_BYTES || stim.size() - r < MIN_RANDOM_BYTES) begin
         row.tchk = 1'b0; row.tst = ST_OK;
         case ($urandom_range(0, 29))
            0:  row.kind = K_SHORT;
            1:  row.kind = K_SIG;
            2:  row.kind = K_NOT32;
            3:  row.kind = K_MARK;
            4, 5: row.kind = K_TRUNC;
            6:  row.kind = K_OVERSIZE;
            7:  row.kind = K_INVALID;
            8:  row.kind = K_BADK;
            9, 10: row.kind = K_BETA;
            11: row.kind = ($urandom_range(0, 7) == 0) ? K_DEEP : K_TRAIL;
            12, 13: row.kind = K_FLIP;
            14: row.kind = K_NOISE;
            default: row.kind = K_GOOD;
         endcase
         queue_chunk(row);
      end
   endfunction

   // ---------------------------------------------------------------
   // Sender, receiver, checker, watchdog
   // ---------------------------------------------------------------
   rsp_expect_type pending_bytes [$];
   int             n_errors = 0;
   int             n_sent = 0;
   int             n_got = 0;
   int             n_chunks = 0;
   int             n_failed_chunks = 0;
   int             idle_cycles = 0;

   initial begin : sender
      int burst, gap;
      magic = '{8'h1b, 8'h4c, 8'h75, 8'h61, 8'h54, 8'h00, 8'h19, 8'h93, 8'h0d,
                8'h0a, 8'h1a, 8'h0a, 8'h04, 8'h04, 8'h04, 8'h78, 8'h56, 8'h00,
                8'h00, 8'h00, 8'h40, 8'hb9, 8'h43};
      walk_clear();
      build_stimulus();
      burst = 0;
      gap = 0;
      while (reset) @(posedge clock);
      while (stim.size() > 0) begin
         @(posedge clock);
         if (push && !full) begin
            pending_bytes.push_back(remap_predict(stim.pop_front()));
            n_sent++;
            if (burst > 0) burst--;
         end
         // bursts of random length, separated by random gaps
         if (burst == 0) begin
            if (gap > 0) gap--;
            else begin
               burst = $urandom_range(1, 40);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (burst > 0 && stim.size() > 0) begin
            push <= 1'b1;
            req_in_byte <= stim[0].b;
            req_chunk_length <= stim[0].len;
         end else begin
            push <= 1'b0;
         end
      end
      while (pending_bytes.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes, %0d results; %0d chunks closed, %0d with an error status",
               n_sent, n_got, n_chunks, n_failed_chunks);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: stall pattern changes mode at the end of each random-length run
   initial begin : receiver
      int mode, run, tick;
      rsp_expect_type e;
      mode = 0; run = 0; tick = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            n_got++;
            if (pending_bytes.size() == 0) begin
               $display("%0t: result beat with nothing expected: byte %h final %b status %0d",
                        $time, rsp_out_byte, rsp_final_res, rsp_status);
               n_errors++;
            end else begin
               e = pending_bytes.pop_front();
               if (rsp_out_byte !== e.ob) begin
                  $display("%0t: out_byte expected %h actual %h", $time, e.ob, rsp_out_byte);
                  n_errors++;
               end
               if (rsp_final_res !== e.fin) begin
                  $display("%0t: final_res expected %b actual %b", $time, e.fin, rsp_final_res);
                  n_errors++;
               end
               if (rsp_status !== e.st || (e.tchk && rsp_status !== e.tst)) begin
                  $display("%0t: status expected %0d (table %0d) actual %0d",
                           $time, e.st, e.tchk ? e.tst : e.st, rsp_status);
                  n_errors++;
               end
               if (e.fin) begin
                  n_chunks++;
                  if (e.st != ST_OK) n_failed_chunks++;
               end
            end
         end
         if (run == 0) begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(20, 200);
         end
         run--;
         tick++;
         case (mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom);
            2: pop <= (tick % 4 == 0);
            default: pop <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, pending_bytes.size());
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
`default_nettype wire
